>>> hdl/cap_pkg.sv
// Package: types, constants and helpers for the cylindrical angle to pixel unit
`timescale 1ns / 1ps
package cap_pkg;

   localparam int MAP_WIDTH_DEFAULT     = 4096;
   localparam int MAP_HEIGHT_DEFAULT    = 4096;
   localparam int CORDIC_STAGES_DEFAULT = 24;

   localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
   localparam logic [31:0]        INV_TWO_PI   = 32'd683565276;

   typedef enum logic [1:0] {
      MODE_SFL  = 2'd0,
      MODE_CAR  = 2'd1,
      MODE_CEA  = 2'd2,
      MODE_CCAR = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE   = 3'd0,
      REG_CRA    = 3'd1,
      REG_CDEC   = 3'd2,
      REG_CTRIG  = 3'd3,
      REG_CX     = 3'd4,
      REG_CY     = 3'd5,
      REG_XPPT   = 3'd6,
      REG_YPPT   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [31:0]        right_ascension;
      logic signed [31:0] declination;
   } req_type;

   typedef struct packed {
      logic [23:0]        pixel_index;
      logic               in_map;
      logic signed [31:0] x_position;
      logic signed [31:0] y_position;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        dalpha;
      logic signed [31:0] dec;
      logic               bad_dec;
   } carry_type;

   // arctangent of 2^-i in binary-angle units
   function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
      unique case (i)
         5'd0:  atan_turn = 34'sd536870912;
         5'd1:  atan_turn = 34'sd316933406;
         5'd2:  atan_turn = 34'sd167458907;
         5'd3:  atan_turn = 34'sd85004756;
         5'd4:  atan_turn = 34'sd42667331;
         5'd5:  atan_turn = 34'sd21354465;
         5'd6:  atan_turn = 34'sd10680862;
         5'd7:  atan_turn = 34'sd5340245;
         5'd8:  atan_turn = 34'sd2670163;
         5'd9:  atan_turn = 34'sd1335087;
         5'd10: atan_turn = 34'sd667544;
         5'd11: atan_turn = 34'sd333772;
         5'd12: atan_turn = 34'sd166886;
         5'd13: atan_turn = 34'sd83443;
         5'd14: atan_turn = 34'sd41722;
         5'd15: atan_turn = 34'sd20861;
         5'd16: atan_turn = 34'sd10430;
         5'd17: atan_turn = 34'sd5215;
         5'd18: atan_turn = 34'sd2608;
         5'd19: atan_turn = 34'sd1304;
         5'd20: atan_turn = 34'sd652;
         5'd21: atan_turn = 34'sd326;
         5'd22: atan_turn = 34'sd163;
         5'd23: atan_turn = 34'sd81;
         5'd24: atan_turn = 34'sd41;
         5'd25: atan_turn = 34'sd20;
         5'd26: atan_turn = 34'sd10;
         5'd27: atan_turn = 34'sd5;
         5'd28: atan_turn = 34'sd3;
         5'd29: atan_turn = 34'sd1;
         5'd30: atan_turn = 34'sd1;
         default: atan_turn = 34'sd0;
      endcase
   endfunction

endpackage

>>> hdl/cap_cordic_cell.sv
// One CORDIC rotation cell: a micro-rotation and a register, carrying the item beside it
`timescale 1ns / 1ps
module cap_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     valid_i,
   input  logic signed [33:0]       x_i,
   input  logic signed [33:0]       y_i,
   input  logic signed [33:0]       z_i,
   input  cap_pkg::carry_type       carry_i,
   output logic                     valid_o,
   output logic signed [33:0]       x_o,
   output logic signed [33:0]       y_o,
   output logic signed [33:0]       z_o,
   output cap_pkg::carry_type       carry_o
);
   import cap_pkg::*;

   logic               valid_ff;
   logic signed [33:0] x_ff, y_ff, z_ff, x_in, y_in, z_in, dx, dy, at;
   carry_type          carry_ff;

   always_comb begin
      dx = y_i >>> STAGE;
      dy = x_i >>> STAGE;
      at = atan_turn(5'(STAGE));
      if (!z_i[33]) begin
         x_in = x_i - dx; y_in = y_i + dy; z_in = z_i - at;
      end else begin
         x_in = x_i + dx; y_in = y_i - dy; z_in = z_i + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_i;
      end
      if (enable) begin
         x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; carry_ff <= carry_i;
      end
   end

   assign valid_o = valid_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign z_o     = z_ff;
   assign carry_o = carry_ff;
endmodule

>>> hdl/cap_scale.sv
// Offset scaling: builds numerators, multiplies by pixels per turn, rounds and places the pixel
`timescale 1ns / 1ps
module cap_scale #(
   parameter int MAP_WIDTH  = 4096,
   parameter int MAP_HEIGHT = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  logic                 valid_i,
   input  logic signed [33:0]   cos_i,
   input  logic signed [33:0]   sin_i,
   input  cap_pkg::carry_type   carry_i,
   input  logic [1:0]           mode,
   input  logic signed [31:0]   center_dec,
   input  logic signed [31:0]   center_trig,
   input  logic signed [31:0]   center_x,
   input  logic signed [31:0]   center_y,
   input  logic [39:0]          x_ppt,
   input  logic [39:0]          y_ppt,
   output logic                 valid_o,
   output cap_pkg::rsp_type     rsp_o
);
   import cap_pkg::*;

   localparam int WX = $clog2(MAP_WIDTH + 1);
   localparam int WY = $clog2(MAP_HEIGHT + 1);

   // stage 1: clamp, factor selection, magnitudes
   logic signed [33:0] cl_cos, cl_sin;
   logic signed [32:0] kx, tdiff;
   logic signed [33:0] ddec;
   logic [32:0]        kmag, amag, tmag;
   logic [32:0]        dmag;
   logic               s1_v_ff, s1_bad_ff, s1_xneg_ff, s1_yneg_ff, s1_cea_ff;
   logic [31:0]        s1_amag_ff;
   logic [31:0]        s1_kmag_ff;
   logic [31:0]        s1_ymag_ff;

   always_comb begin
      cl_cos = cos_i;
      if (cl_cos < 0) cl_cos = '0;
      if (cl_cos > QUARTER_TURN) cl_cos = QUARTER_TURN;
      cl_sin = sin_i;
      if (cl_sin < -QUARTER_TURN) cl_sin = -QUARTER_TURN;
      if (cl_sin > QUARTER_TURN) cl_sin = QUARTER_TURN;
      unique case (mode_type'(mode))
         MODE_SFL:  kx = 33'(cl_cos);
         MODE_CCAR: kx = 33'(center_trig);
         default:   kx = 33'(QUARTER_TURN);
      endcase
      kmag  = kx[32] ? 33'(-kx) : 33'(kx);
      amag  = carry_i.dalpha[31] ? 33'(-$signed({1'b1, carry_i.dalpha}))
                                 : {1'b0, carry_i.dalpha};
      tdiff = 33'($signed(center_trig) - cl_sin);
      tmag  = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
      ddec  = 34'(center_dec) - 34'(carry_i.dec);
      dmag  = ddec[33] ? 33'(-ddec) : 33'(ddec);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (enable) s1_v_ff <= valid_i;
      if (enable) begin
         s1_bad_ff  <= carry_i.bad_dec;
         s1_cea_ff  <= (mode == MODE_CEA);
         s1_amag_ff <= amag[31:0];
         s1_kmag_ff <= kmag[31:0];
         s1_xneg_ff <= (carry_i.dalpha[31] ^ kx[32]) && amag != 0 && kmag != 0;
         if (mode == MODE_CEA) begin
            s1_ymag_ff <= tmag[31:0];
            s1_yneg_ff <= tdiff[32];
         end else begin
            s1_ymag_ff <= dmag[31:0];
            s1_yneg_ff <= ddec[33];
         end
      end
   end

   // stage 2: numerator magnitudes (x: 32x32; y: shift or 32x32)
   logic        s2_v_ff, s2_bad_ff, s2_xneg_ff, s2_yneg_ff;
   logic [62:0] s2_xn_ff, s2_yn_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (enable) s2_v_ff <= s1_v_ff;
      if (enable) begin
         s2_bad_ff  <= s1_bad_ff;
         s2_xneg_ff <= s1_xneg_ff;
         s2_yneg_ff <= s1_yneg_ff;
         s2_xn_ff   <= 63'(s1_amag_ff) * 63'(s1_kmag_ff);
         s2_yn_ff   <= s1_cea_ff ? 63'(64'(s1_ymag_ff) * 64'(INV_TWO_PI))
                                 : 63'({s1_ymag_ff, 30'd0});
      end
   end

   // stage 3: partial products of numerator by ppt, split at 32 bits
   logic        s3_v_ff, s3_bad_ff, s3_xneg_ff, s3_yneg_ff;
   logic [63:0] s3_x00_ff, s3_x01_ff, s3_x10_ff, s3_x11_ff;
   logic [63:0] s3_y00_ff, s3_y01_ff, s3_y10_ff, s3_y11_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (enable) s3_v_ff <= s2_v_ff;
      if (enable) begin
         s3_bad_ff  <= s2_bad_ff;
         s3_xneg_ff <= s2_xneg_ff;
         s3_yneg_ff <= s2_yneg_ff;
         s3_x00_ff  <= 64'(s2_xn_ff[31:0])  * 64'(x_ppt[31:0]);
         s3_x01_ff  <= 64'(s2_xn_ff[31:0])  * 64'(x_ppt[39:32]);
         s3_x10_ff  <= 64'(s2_xn_ff[62:32]) * 64'(x_ppt[31:0]);
         s3_x11_ff  <= 64'(s2_xn_ff[62:32]) * 64'(x_ppt[39:32]);
         s3_y00_ff  <= 64'(s2_yn_ff[31:0])  * 64'(y_ppt[31:0]);
         s3_y01_ff  <= 64'(s2_yn_ff[31:0])  * 64'(y_ppt[39:32]);
         s3_y10_ff  <= 64'(s2_yn_ff[62:32]) * 64'(y_ppt[31:0]);
         s3_y11_ff  <= 64'(s2_yn_ff[62:32]) * 64'(y_ppt[39:32]);
      end
   end

   // stage 4: sum, round at bit 61, shift down, apply sign and subtract
   logic [103:0] xfull, yfull;
   logic [41:0]  xoff, yoff;
   logic signed [43:0] xpos, ypos;
   always_comb begin
      xfull = 104'(s3_x00_ff) + {8'd0, s3_x01_ff, 32'd0} + {8'd0, s3_x10_ff, 32'd0}
            + {s3_x11_ff[39:0], 64'd0} + (104'd1 << 61);
      yfull = 104'(s3_y00_ff) + {8'd0, s3_y01_ff, 32'd0} + {8'd0, s3_y10_ff, 32'd0}
            + {s3_y11_ff[39:0], 64'd0} + (104'd1 << 61);
      xoff = xfull[103:62];
      yoff = yfull[103:62];
      xpos = 44'(center_x) - (s3_xneg_ff ? -$signed({2'b0, xoff}) : $signed({2'b0, xoff}));
      ypos = 44'(center_y) - (s3_yneg_ff ? -$signed({2'b0, yoff}) : $signed({2'b0, yoff}));
   end

   logic               s4_v_ff, s4_bad_ff;
   logic signed [43:0] s4_x_ff, s4_y_ff;
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (enable) s4_v_ff <= s3_v_ff;
      if (enable) begin
         s4_bad_ff <= s3_bad_ff;
         s4_x_ff   <= xpos;
         s4_y_ff   <= ypos;
      end
   end

   // stage 5: grid test, pixel index, saturation
   logic signed [44:0] xr, yr;
   logic [28:0]        cx, cy;
   logic               okx, oky;
   logic [31:0]        xs, ys;
   rsp_type            r_in, r_ff;
   logic               v5_ff;
   logic [47:0]        pix;
   always_comb begin
      xr  = 45'(s4_x_ff) + 45'sd32768;
      yr  = 45'(s4_y_ff) + 45'sd32768;
      cx  = xr[44:16];
      cy  = yr[44:16];
      okx = !xr[44] && (cx < 29'(MAP_WIDTH));
      oky = !yr[44] && (cy < 29'(MAP_HEIGHT));
      xs  = (s4_x_ff > 44'sd2147483647) ? 32'h7FFFFFFF :
            (s4_x_ff < -44'sd2147483648) ? 32'h80000000 : s4_x_ff[31:0];
      ys  = (s4_y_ff > 44'sd2147483647) ? 32'h7FFFFFFF :
            (s4_y_ff < -44'sd2147483648) ? 32'h80000000 : s4_y_ff[31:0];
      pix = 48'(cx[WX-1:0]) + 48'(cy[WY-1:0]) * 48'(MAP_WIDTH);
      r_in = '0;
      if (!s4_bad_ff) begin
         r_in.x_position = xs;
         r_in.y_position = ys;
         if (okx && oky) begin
            r_in.in_map      = 1'b1;
            r_in.pixel_index = pix[23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (enable) v5_ff <= s4_v_ff;
      if (enable) r_ff <= r_in;
   end

   assign valid_o = v5_ff;
   assign rsp_o   = r_ff;
endmodule

>>> hdl/cylindrical_angle_to_pixel_unit.sv
// Top level: cylindrical sky direction to map pixel, CORDIC cell chain and scaling pipeline
`timescale 1ns / 1ps
// Accepts one sky direction a cycle while the result is not stalled and returns one pixel
// result per direction, in order. The pipeline is the chain of CORDIC cells (one
// micro-rotation per cell) followed by the five-stage scaling pipeline, whose 40-bit by
// 63-bit offset product is split at 32 bits into partial products. The whole pipeline
// advances whenever the output register is empty or being taken, so a stalled result
// holds every stage; req_ready follows rsp_ready in that way. Write configuration only
// when no beat is in flight.
module cylindrical_angle_to_pixel_unit #(
   parameter int MAP_WIDTH     = cap_pkg::MAP_WIDTH_DEFAULT,
   parameter int MAP_HEIGHT    = cap_pkg::MAP_HEIGHT_DEFAULT,
   parameter int CORDIC_STAGES = cap_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cap_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cap_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [39:0]      csr_data
);
   import cap_pkg::*;

   logic [1:0]         mode_ff;
   logic [31:0]        cra_ff;
   logic signed [31:0] cdec_ff, ctrig_ff, cx_ff, cy_ff;
   logic [39:0]        xppt_ff, yppt_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_CAR;
         cra_ff   <= '0;
         cdec_ff  <= '0;
         ctrig_ff <= 32'sd1073741824;
         cx_ff    <= 32'sd134184960;
         cy_ff    <= 32'sd134184960;
         xppt_ff  <= 40'd1415577600;
         yppt_ff  <= 40'd1415577600;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_MODE:  mode_ff  <= csr_data[1:0];
            REG_CRA:   cra_ff   <= csr_data[31:0];
            REG_CDEC:  cdec_ff  <= csr_data[31:0];
            REG_CTRIG: ctrig_ff <= csr_data[31:0];
            REG_CX:    cx_ff    <= csr_data[31:0];
            REG_CY:    cy_ff    <= csr_data[31:0];
            REG_XPPT:  xppt_ff  <= csr_data;
            REG_YPPT:  yppt_ff  <= csr_data;
         endcase
      end
   end

   // advance everything together unless the result register holds an untaken beat
   logic enable;
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   logic               v   [CORDIC_STAGES+1];
   logic signed [33:0] x   [CORDIC_STAGES+1];
   logic signed [33:0] y   [CORDIC_STAGES+1];
   logic signed [33:0] z   [CORDIC_STAGES+1];
   carry_type          c   [CORDIC_STAGES+1];

   // an out-of-range declination still rides the chain; its result is forced to zero
   always_comb begin
      v[0] = req_valid;
      x[0] = CORDIC_GAIN;
      y[0] = '0;
      z[0] = 34'(req_data.declination);
      c[0].dalpha  = req_data.right_ascension - cra_ff;
      c[0].dec     = req_data.declination;
      c[0].bad_dec = (req_data.declination > 32'sd1073741824) ||
                     (req_data.declination < -32'sd1073741824);
   end

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      cap_cordic_cell #(.STAGE(g)) u_cell (
         .clock(clock), .reset(reset), .enable(enable),
         .valid_i(v[g]), .x_i(x[g]), .y_i(y[g]), .z_i(z[g]), .carry_i(c[g]),
         .valid_o(v[g+1]), .x_o(x[g+1]), .y_o(y[g+1]), .z_o(z[g+1]), .carry_o(c[g+1])
      );
   end

   cap_scale #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_scale (
      .clock(clock), .reset(reset), .enable(enable),
      .valid_i(v[CORDIC_STAGES]), .cos_i(x[CORDIC_STAGES]), .sin_i(y[CORDIC_STAGES]),
      .carry_i(c[CORDIC_STAGES]), .mode(mode_ff), .center_dec(cdec_ff),
      .center_trig(ctrig_ff), .center_x(cx_ff), .center_y(cy_ff),
      .x_ppt(xppt_ff), .y_ppt(yppt_ff),
      .valid_o(rsp_valid), .rsp_o(rsp_data)
   );
endmodule

>>> hdl/cap_checker.sv
// Port checker for the cylindrical angle to pixel unit, bound to the top level
`timescale 1ns / 1ps
module cap_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cap_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalls");
   a_off_map_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_map |-> rsp_data.pixel_index == 24'd0)
      else $error("off-map result carries a pixel index");
endmodule

bind cylindrical_angle_to_pixel_unit cap_checker u_cap_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

>>> verif/cylindrical_angle_to_pixel_unit_test.sv
// Testbench: randomised stream check of the cylindrical angle to pixel unit against a predictor
`timescale 1ns / 1ps
module cylindrical_angle_to_pixel_unit_test;
   import cap_pkg::*;

   localparam int MAP_W   = 4096;
   localparam int MAP_H   = 4096;
   localparam int STAGES  = 24;
   localparam int LATENCY = STAGES + 5;
   localparam logic signed [63:0] QTR = 64'sd1073741824;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [39:0] csr_data = '0;

   // shadow copy of the configuration registers
   logic [1:0]  sh_mode;
   logic [31:0] sh_cra, sh_cdec, sh_ctrig, sh_cx, sh_cy;
   logic [39:0] sh_xppt, sh_yppt;

   req_type pending_dirs[$];
   rsp_type expected_pixels[$];
   int      error_count = 0;
   bit      rx_idle_ok = 1'b1;   // cleared for the long stretch without idling
   bit      tx_idle_ok = 1'b1;
   bit      stall_go = 1'b0;     // starts the long receiver stall
   bit      hold_rx = 1'b0;      // receiver back-pressure in force
   logic    req_ready_seen = 1'b0;

   cylindrical_angle_to_pixel_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // round(mag * ppt / 2^62), halves up on the magnitude, sign restored
   function automatic logic signed [63:0] scaled_offset(input logic signed [63:0] num,
                                                        input logic [39:0] ppt);
      logic [63:0]  mag;
      logic [127:0] prod;
      mag  = num < 0 ? -num : num;
      prod = mag * ppt + (128'd1 << 61);
      return num < 0 ? -$signed(prod[125:62]) : $signed(prod[125:62]);
   endfunction

   function automatic logic [31:0] saturate32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   // own copy of the arctangent table, binary-angle units
   function automatic logic signed [63:0] atan_tab(input int i);
      int t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                    10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
                    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
                    10, 5, 3, 1, 1, 0};
      return 64'(t[i]);
   endfunction

   function automatic rsp_type predict_pixel(input req_type d);
      rsp_type r;
      logic signed [63:0] dec, dalpha, trig, x, y, z, dx, dy, kx, xnum, ynum, diff, xpos, ypos;
      logic signed [63:0] vx, vy;
      logic [63:0] mag;
      logic [31:0] da;
      r = '0;
      da     = d.right_ascension - sh_cra;
      dec    = $signed(d.declination);
      dalpha = $signed(da);
      trig   = $signed(sh_ctrig);
      if (dec > QTR || dec < -QTR) return r;
      x = 64'sd652032874; y = 0; z = dec;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_tab(i);
         end else begin
            x = x + dx; y = y - dy; z = z + atan_tab(i);
         end
      end
      if (x < 0) x = 0;
      if (x > QTR) x = QTR;
      if (y < -QTR) y = -QTR;
      if (y > QTR) y = QTR;
      case (mode_type'(sh_mode))
         MODE_SFL:  kx = x;
         MODE_CCAR: kx = trig;
         default:   kx = QTR;
      endcase
      xnum = dalpha * kx;
      if (mode_type'(sh_mode) == MODE_CEA) begin
         diff = trig - y;
         mag  = (diff < 0 ? -diff : diff) * 64'd683565276;
         ynum = diff < 0 ? -$signed(mag) : $signed(mag);
      end else begin
         ynum = ($signed(sh_cdec) - dec) * QTR;
      end
      xpos = $signed(sh_cx) - scaled_offset(xnum, sh_xppt);
      ypos = $signed(sh_cy) - scaled_offset(ynum, sh_yppt);
      vx = (xpos + 32768) >>> 16;
      vy = (ypos + 32768) >>> 16;
      if (xpos + 32768 >= 0 && ypos + 32768 >= 0 && vx < MAP_W && vy < MAP_H) begin
         r.in_map = 1'b1;
         r.pixel_index = 24'(vx + vy * MAP_W);
      end
      r.x_position = saturate32(xpos);
      r.y_position = saturate32(ypos);
      return r;
   endfunction

   // driver: offer queued directions at the falling edge, hold until accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_seen) begin
            if (pending_dirs.size() > 0 && !(tx_idle_ok && $urandom_range(99) < 11)) begin
               req_data  <= pending_dirs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (hold_rx) rsp_ready <= 1'b0;
         else rsp_ready <= !(rx_idle_ok && $urandom_range(99) < 11);
      end
   end

   // record acceptance at the rising edge so the driver knows the beat has gone
   always @(posedge clock) begin
      req_ready_seen <= req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         expected_pixels = {expected_pixels, predict_pixel(req_data)};
   end

   // long receiver stall, counted here in cycles
   initial begin
      wait (stall_go);
      hold_rx = 1'b1;
      repeat (200) @(posedge clock);
      hold_rx = 1'b0;
   end

   // monitor: compare each result beat with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected result beat");
            error_count++;
         end else begin
            e = expected_pixels.pop_front();
            if (e.pixel_index !== rsp_data.pixel_index) begin
               $error("pixel_index exp %0d got %0d", e.pixel_index, rsp_data.pixel_index);
               error_count++;
            end
            if (e.in_map !== rsp_data.in_map) begin
               $error("in_map exp %0d got %0d", e.in_map, rsp_data.in_map);
               error_count++;
            end
            if (e.x_position !== rsp_data.x_position) begin
               $error("x_position exp %0d got %0d", e.x_position, rsp_data.x_position);
               error_count++;
            end
            if (e.y_position !== rsp_data.y_position) begin
               $error("y_position exp %0d got %0d", e.y_position, rsp_data.y_position);
               error_count++;
            end
         end
      end
   end

   task automatic write_reg(input reg_index_type idx, input logic [39:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MODE:  sh_mode  = value[1:0];
         REG_CRA:   sh_cra   = value[31:0];
         REG_CDEC:  sh_cdec  = value[31:0];
         REG_CTRIG: sh_ctrig = value[31:0];
         REG_CX:    sh_cx    = value[31:0];
         REG_CY:    sh_cy    = value[31:0];
         REG_XPPT:  sh_xppt  = value;
         default:   sh_yppt  = value;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for all queued and in-flight beats to drain
   task automatic drain();
      while (pending_dirs.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_dec();
      case ($urandom_range(9))
         0: return $urandom();                      // anything, about half beyond the pole
         1: return 32'sd1073741824;
         2: return -32'sd1073741824;
         3: return $urandom_range(3) + 32'sd1073741823;
         default: return $signed($urandom_range(32'h7fffffff)) - 32'sd1073741824;
      endcase
   endfunction

   // queue a direction near the centre so most land on the grid
   task automatic push_near(input int spread);
      req_type d;
      d.right_ascension = sh_cra + $signed($urandom_range(2 * spread) - spread);
      d.declination     = $urandom_range(3) == 0 ? pick_dec()
                          : $signed(sh_cdec) + $signed($urandom_range(2 * spread) - spread);
      pending_dirs = {pending_dirs, d};
   endtask

   initial begin
      req_type d;
      int n;
      sh_mode = 2'd1; sh_cra = 0; sh_cdec = 0; sh_ctrig = 32'd1073741824;
      sh_cx = 32'd134184960; sh_cy = 32'd134184960;
      sh_xppt = 40'd1415577600; sh_yppt = 40'd1415577600;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes and pole cases under reset settings
      for (int i = 0; i < 16; i++) begin
         d.right_ascension = (i % 4 == 0) ? 32'h0 : (i % 4 == 1) ? 32'hffffffff :
                             (i % 4 == 2) ? 32'h80000000 : 32'h00100000;
         case (i / 4)
            0: d.declination = 32'sd1073741824;
            1: d.declination = -32'sd1073741824;
            2: d.declination = 32'sd1073741825;
            default: d.declination = (i % 2) ? 32'h7fffffff : 32'h80000000;
         endcase
         pending_dirs = {pending_dirs, d};
      end
      for (int i = 0; i < 8; i++) push_near(1 << 20);
      drain();

      // every mode, extremes of each register, random phases
      for (int phase = 0; phase < 12; phase++) begin
         write_reg(REG_MODE, 40'(phase % 4));
         write_reg(REG_CRA, 40'(phase == 1 ? 32'hffffffff : $urandom()));
         write_reg(REG_CDEC, 40'(phase == 2 ? 32'sd1073741824 : phase == 3 ? -32'sd1073741824
                   : $signed($urandom_range(32'h7fffffff)) - 32'sd1073741824));
         write_reg(REG_CTRIG, 40'(phase == 4 ? -32'sd1073741824 : phase == 5 ? 32'sd1073741824
                   : $signed($urandom_range(32'h7fffffff)) - 32'sd1073741824));
         write_reg(REG_CX, 40'(phase == 6 ? 32'h7fffffff : phase == 7 ? 32'h80000000
                   : $urandom_range(32'h10000000)));
         write_reg(REG_CY, 40'(phase == 6 ? 32'h80000000 : phase == 7 ? 32'h7fffffff
                   : $urandom_range(32'h10000000)));
         write_reg(REG_XPPT, phase == 8 ? 40'h0 : phase == 9 ? 40'hffffffffff
                   : 40'({8'($urandom_range(255)), $urandom()} >> $urandom_range(8)));
         write_reg(REG_YPPT, phase == 8 ? 40'hffffffffff : phase == 9 ? 40'h0
                   : 40'({8'($urandom_range(255)), $urandom()} >> $urandom_range(8)));
         tx_idle_ok = (phase != 5);
         rx_idle_ok = (phase != 5);
         n = 50;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(4) == 0) begin
               d.right_ascension = $urandom();
               d.declination     = pick_dec();
               pending_dirs = {pending_dirs, d};
            end else begin
               push_near(1 << $urandom_range(10, 26));
            end
         end
         if (phase == 3) stall_go = 1'b1;   // long receiver stall to fill the pipeline
         drain();
      end
      tx_idle_ok = 1'b1;
      rx_idle_ok = 1'b1;
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule

>>> cylindrical_angle_to_pixel_unit.f
hdl/cap_pkg.sv
hdl/cap_cordic_cell.sv
hdl/cap_scale.sv
hdl/cylindrical_angle_to_pixel_unit.sv
hdl/cap_checker.sv
verif/cylindrical_angle_to_pixel_unit_test.sv
